// ===== rtl/core/mtw_pkg.sv =====
// Shared types and constants for the multi-task watchdog.
// Holds field widths, item kind and status codes, the controller state type
// and the result beat structure. Depends on nothing.
package mtw_pkg;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 8;
    localparam int PTIME_W  = 24;
    localparam int STAT_W   = 3;
    localparam int TICK_W   = 10;

    localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

    localparam logic [KIND_W-1:0] K_REGISTER   = 3'd0;
    localparam logic [KIND_W-1:0] K_UNREGISTER = 3'd1;
    localparam logic [KIND_W-1:0] K_KICK       = 3'd2;
    localparam logic [KIND_W-1:0] K_TICK       = 3'd3;
    localparam logic [KIND_W-1:0] K_STATUS     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ID   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_TIME = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FINAL = 3'b100
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PTIME_W-1:0] time_left;
        logic [ID_W-1:0]    expired_id;
        logic               expired_action;
        logic               last;
    } result_t;

endpackage

// ===== rtl/core/mtw_slot_ram.sv =====
// Slot record memory: one write port and one registered read port.
// Each entry holds id, recovery action, period and time left.
// Depends on nothing.
module mtw_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 57
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mtw_ctrl.sv =====
// Watchdog sequencer: walks the slot memory once per item, reading,
// updating and writing back records, and issues result beats.
// Depends on mtw_pkg.
module mtw_ctrl #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mtw_pkg::KIND_W-1:0]  kind,
    input  logic [mtw_pkg::ID_W-1:0]    task_id,
    input  logic [mtw_pkg::PTIME_W-1:0] reload_time,
    input  logic                        fail_action,
    input  logic [mtw_pkg::TICK_W-1:0]  tick_ms,
    output logic                        busy,
    output logic                        mem_we,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_waddr,
    output logic [mtw_pkg::ID_W+1+2*TIME_BITS-1:0]      mem_wdata,
    output logic                        mem_re,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_raddr,
    input  logic [mtw_pkg::ID_W+1+2*TIME_BITS-1:0]      mem_rdata,
    output logic                        strobe,
    output mtw_pkg::result_t            result
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = IW + 1;
    localparam int UW   = $clog2(SLOTS + 1);
    localparam int TB   = TIME_BITS;
    localparam int RW   = mtw_pkg::ID_W + 1 + 2 * TB;
    localparam int WW   = (TB > mtw_pkg::PTIME_W) ? TB : mtw_pkg::PTIME_W;
    localparam int CW   = (TB > mtw_pkg::TICK_W) ? TB : mtw_pkg::TICK_W;

    mtw_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            p_vld_reg, p_vld_next;
    logic [IW-1:0]   p_idx_reg, p_idx_next;
    logic [mtw_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [mtw_pkg::ID_W-1:0]   id_reg, id_next;
    logic [TB-1:0]   tmo_reg, tmo_next;
    logic            act_reg, act_next;
    logic            match_found_reg, match_found_next;
    logic [IW-1:0]   match_idx_reg, match_idx_next;
    logic [TB-1:0]   match_period_reg, match_period_next;
    logic [TB-1:0]   match_left_reg, match_left_next;
    logic            match_act_reg, match_act_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic            pend_vld_reg, pend_vld_next;
    logic [mtw_pkg::ID_W-1:0] pend_id_reg, pend_id_next;
    logic            pend_act_reg, pend_act_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [UW-1:0]   used_reg, used_next;
    logic            strobe_reg, strobe_next;
    mtw_pkg::result_t res_reg, res_next;

    logic [mtw_pkg::ID_W-1:0] r_id;
    logic            r_act;
    logic [TB-1:0]   r_period;
    logic [TB-1:0]   r_left;
    logic            slot_on;
    logic            expire;
    logic [CW-1:0]   diff;
    logic [WW-1:0]   tmo_ext;
    logic [WW-1:0]   tmax_ext;
    logic [WW-1:0]   tmo_sat;
    logic [WW-1:0]   rem_ext;

    assign r_id     = mem_rdata[RW-1 -: mtw_pkg::ID_W];
    assign r_act    = mem_rdata[2*TB];
    assign r_period = mem_rdata[2*TB-1:TB];
    assign r_left   = mem_rdata[TB-1:0];
    assign slot_on  = active_reg[p_idx_reg];
    assign expire   = CW'(r_left) <= CW'(tick_ms);
    assign diff     = CW'(r_left) - CW'(tick_ms);
    assign tmo_ext  = WW'(reload_time);
    assign tmax_ext = WW'({TB{1'b1}});
    assign tmo_sat  = (tmo_ext > tmax_ext) ? tmax_ext : tmo_ext;
    assign rem_ext  = WW'(match_left_reg);

    assign busy      = state_reg != mtw_pkg::S_IDLE;
    assign mem_re    = (state_reg == mtw_pkg::S_WALK) && (cnt_reg < CNTW'(SLOTS));
    assign mem_raddr = cnt_reg[IW-1:0];
    assign strobe    = strobe_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        p_vld_next        = p_vld_reg;
        p_idx_next        = p_idx_reg;
        kind_next         = kind_reg;
        id_next           = id_reg;
        tmo_next          = tmo_reg;
        act_next          = act_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        match_period_next = match_period_reg;
        match_left_next   = match_left_reg;
        match_act_next    = match_act_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        pend_vld_next     = pend_vld_reg;
        pend_id_next      = pend_id_reg;
        pend_act_next     = pend_act_reg;
        active_next       = active_reg;
        used_next         = used_reg;
        strobe_next       = 1'b0;
        res_next          = '0;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;

        case (state_reg)
            mtw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next        = kind;
                    id_next          = task_id;
                    tmo_next         = tmo_sat[TB-1:0];
                    act_next         = fail_action;
                    cnt_next         = '0;
                    p_vld_next       = 1'b0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    pend_vld_next    = 1'b0;
                    state_next       = mtw_pkg::S_WALK;
                end
            end
            mtw_pkg::S_WALK:
            begin
                p_vld_next = cnt_reg < CNTW'(SLOTS);
                p_idx_next = cnt_reg[IW-1:0];
                if (cnt_reg < CNTW'(SLOTS))
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
                else
                begin
                    state_next = mtw_pkg::S_FINAL;
                end
                if (p_vld_reg)
                begin
                    if (slot_on && (r_id == id_reg) && !match_found_reg)
                    begin
                        match_found_next  = 1'b1;
                        match_idx_next    = p_idx_reg;
                        match_period_next = r_period;
                        match_left_next   = r_left;
                        match_act_next    = r_act;
                    end
                    if (!slot_on && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = p_idx_reg;
                    end
                    if ((kind_reg == mtw_pkg::K_TICK) && slot_on)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = p_idx_reg;
                        mem_wdata = {r_id, r_act, r_period,
                                     expire ? r_period : diff[TB-1:0]};
                        if (expire)
                        begin
                            if (pend_vld_reg)
                            begin
                                strobe_next             = 1'b1;
                                res_next.status         = mtw_pkg::ST_TIMEOUT;
                                res_next.expired_id     = pend_id_reg;
                                res_next.expired_action = pend_act_reg;
                            end
                            pend_vld_next = 1'b1;
                            pend_id_next  = r_id;
                            pend_act_next = r_act;
                        end
                    end
                end
            end
            mtw_pkg::S_FINAL:
            begin
                state_next = mtw_pkg::S_IDLE;
                case (kind_reg)
                    mtw_pkg::K_REGISTER:
                    begin
                        strobe_next   = 1'b1;
                        res_next.last = 1'b1;
                        if (tmo_reg == '0)
                        begin
                            res_next.status = mtw_pkg::ST_BAD_TIME;
                        end
                        else if (id_reg == '0)
                        begin
                            res_next.status = mtw_pkg::ST_BAD_ID;
                        end
                        else if (used_reg >= UW'(SLOTS))
                        begin
                            res_next.status = mtw_pkg::ST_FULL;
                        end
                        else if (match_found_reg)
                        begin
                            res_next.status = mtw_pkg::ST_BAD_ID;
                        end
                        else if (!free_found_reg)
                        begin
                            res_next.status = mtw_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_next.status            = mtw_pkg::ST_OK;
                            mem_we                     = 1'b1;
                            mem_waddr                  = free_idx_reg;
                            mem_wdata                  = {id_reg, act_reg, tmo_reg, tmo_reg};
                            active_next[free_idx_reg]  = 1'b1;
                            used_next                  = used_reg + UW'(1);
                        end
                    end
                    mtw_pkg::K_UNREGISTER, mtw_pkg::K_KICK, mtw_pkg::K_STATUS:
                    begin
                        strobe_next   = 1'b1;
                        res_next.last = 1'b1;
                        if ((id_reg == '0) || !match_found_reg)
                        begin
                            res_next.status = mtw_pkg::ST_BAD_ID;
                        end
                        else
                        begin
                            res_next.status = mtw_pkg::ST_OK;
                            if (kind_reg == mtw_pkg::K_UNREGISTER)
                            begin
                                active_next[match_idx_reg] = 1'b0;
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - UW'(1);
                                end
                            end
                            else if (kind_reg == mtw_pkg::K_KICK)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = match_idx_reg;
                                mem_wdata = {id_reg, match_act_reg,
                                             match_period_reg, match_period_reg};
                            end
                            else
                            begin
                                res_next.time_left = rem_ext[mtw_pkg::PTIME_W-1:0];
                            end
                        end
                    end
                    mtw_pkg::K_TICK:
                    begin
                        if (pend_vld_reg)
                        begin
                            strobe_next             = 1'b1;
                            res_next.status         = mtw_pkg::ST_TIMEOUT;
                            res_next.expired_id     = pend_id_reg;
                            res_next.expired_action = pend_act_reg;
                            res_next.last           = 1'b1;
                        end
                        pend_vld_next = 1'b0;
                    end
                    default:
                    begin
                        strobe_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = mtw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mtw_pkg::S_IDLE;
            cnt_reg         <= '0;
            p_vld_reg       <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_vld_reg    <= 1'b0;
            active_reg      <= '0;
            used_reg        <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            p_vld_reg       <= p_vld_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            pend_vld_reg    <= pend_vld_next;
            active_reg      <= active_next;
            used_reg        <= used_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg        <= p_idx_next;
        kind_reg         <= kind_next;
        id_reg           <= id_next;
        tmo_reg          <= tmo_next;
        act_reg          <= act_next;
        match_idx_reg    <= match_idx_next;
        match_period_reg <= match_period_next;
        match_left_reg   <= match_left_next;
        match_act_reg    <= match_act_next;
        free_idx_reg     <= free_idx_next;
        pend_id_reg      <= pend_id_next;
        pend_act_reg     <= pend_act_next;
        res_reg          <= res_next;
    end

endmodule

// ===== rtl/core/multi_task_watchdog_top.sv =====
// Multi-task watchdog top level: every item walks all SLOTS records of the slot memory,
// so an item keeps busy high through the walk and the final step, and no new item is taken until busy is low.
// Timeout beats of a tick come out during the walk, at most one per cycle; the final beat
// is on the ports in the first cycle with busy low. The receiver cannot stall.
// Reset clears all slots to inactive and tick_ms to 10 at once; no clearing pass is needed.
// Depends on mtw_pkg, mtw_slot_ram and mtw_ctrl.
module multi_task_watchdog_top #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mtw_pkg::KIND_W-1:0]  kind,
    input  logic [mtw_pkg::ID_W-1:0]    task_id,
    input  logic [mtw_pkg::PTIME_W-1:0] reload_time,
    input  logic                        fail_action,
    input  logic                        cfg_we,
    input  logic [mtw_pkg::TICK_W-1:0]  cfg_wdata,
    output logic                        strobe,
    output logic [mtw_pkg::STAT_W-1:0]  status,
    output logic [mtw_pkg::PTIME_W-1:0] time_left,
    output logic [mtw_pkg::ID_W-1:0]    expired_id,
    output logic                        expired_action,
    output logic                        last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = mtw_pkg::ID_W + 1 + 2 * TIME_BITS;

    logic [mtw_pkg::TICK_W-1:0] tick_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [RW-1:0] mem_rdata;
    mtw_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= mtw_pkg::TICK_RESET;
        end
        else if (cfg_we)
        begin
            tick_reg <= cfg_wdata;
        end
    end

    mtw_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW),
        .DW    (RW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mtw_ctrl #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .kind            (kind),
        .task_id         (task_id),
        .reload_time     (reload_time),
        .fail_action     (fail_action),
        .tick_ms         (tick_reg),
        .busy            (busy),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .strobe          (strobe),
        .result          (result)
    );

    assign status         = result.status;
    assign time_left      = result.time_left;
    assign expired_id     = result.expired_id;
    assign expired_action = result.expired_action;
    assign last           = result.last;

endmodule

// ===== rtl/core/mtw_checker.sv =====
// Port-level checker for the multi-task watchdog, bound to the top level.
// Depends on mtw_pkg and multi_task_watchdog_top.
module mtw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        strobe,
    input logic [mtw_pkg::STAT_W-1:0]  status,
    input logic [mtw_pkg::PTIME_W-1:0] time_left,
    input logic [mtw_pkg::ID_W-1:0]    expired_id,
    input logic                        expired_action,
    input logic                        last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Busy did not rise after an item was accepted.");

    a_beat_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("A result beat appeared with no item in progress.");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != mtw_pkg::ST_TIMEOUT)) |-> last)
        else $error("A command reply beat was not marked last.");

    a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == mtw_pkg::ST_TIMEOUT)) |-> (time_left == '0))
        else $error("A timeout beat carried a remaining time.");

    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != mtw_pkg::ST_TIMEOUT))
            |-> ((expired_id == '0) && !expired_action))
        else $error("A command reply beat carried expiry fields.");

endmodule

bind multi_task_watchdog_top mtw_checker u_mtw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .strobe         (strobe),
    .status         (status),
    .time_left      (time_left),
    .expired_id     (expired_id),
    .expired_action (expired_action),
    .last           (last)
);
